/* hdl/crlf_pkg.sv */
package crlf_pkg;

   localparam int LINKS      = 4;
   localparam int LINK_W     = 2;
   localparam int BUF_DEPTH  = 512;
   localparam int POS_W      = 9;
   localparam int FILL_W     = 10;
   localparam int CHUNK      = 8;
   localparam int CNT_W      = 4;
   localparam int MAXLEN_W   = 9;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [MAXLEN_W-1:0] FRAME_CAP = 9'd256;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POLL = 1'b1;

   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_NO_TERM = 2'd1;
   localparam logic [1:0] ST_DROP    = 2'd2;
   localparam logic [1:0] ST_FRAME   = 2'd3;

   typedef struct packed {
      logic              action;
      logic [LINK_W-1:0] link;
      logic [7:0]        in_byte;
   } item_type;

   typedef struct packed {
      logic [LINK_W-1:0]           out_link;
      logic [1:0]                  status;
      logic [CHUNK-1:0][7:0]       bytes;
      logic [CNT_W-1:0]            byte_count;
      logic                        last;
   } rsp_type;

endpackage

/* hdl/crlf_front.sv */
module crlf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  crlf_pkg::item_type req_item,
   output logic               q_valid,
   output crlf_pkg::item_type q_item,
   input  logic               q_pop
);

   // Two-entry queue between the accepting side and the execution engine.
   crlf_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* hdl/crlf_back.sv */
module crlf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  crlf_pkg::item_type                q_item,
   output logic                              q_pop,
   input  logic [crlf_pkg::MAXLEN_W-1:0]     max_len,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output crlf_pkg::rsp_type                 rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_EMIT_RD, S_EMIT_CAP,
      S_EMIT_OUT, S_TAIL_RD, S_TAIL_CHK, S_SIMPLE_OUT
   } state_type;

   localparam int AW = crlf_pkg::LINK_W + crlf_pkg::POS_W;

   logic [7:0] mem [crlf_pkg::LINKS*crlf_pkg::BUF_DEPTH];
   logic [7:0] rdata_ff;

   state_type state_ff;
   logic [crlf_pkg::POS_W-1:0]  rp_ff   [crlf_pkg::LINKS];
   logic [crlf_pkg::FILL_W-1:0] fill_ff [crlf_pkg::LINKS];
   logic [crlf_pkg::LINK_W-1:0] link_ff;
   logic [crlf_pkg::FILL_W-1:0] cur_fill_ff;
   logic [crlf_pkg::FILL_W-1:0] off_ff;
   logic [crlf_pkg::FILL_W-1:0] term_ff;
   logic [crlf_pkg::FILL_W-1:0] lf_pos_ff;
   logic [crlf_pkg::FILL_W-1:0] len_ff;
   logic cr_found_ff;
   logic lf_found_ff;
   logic [crlf_pkg::CNT_W-1:0] k_ff;
   logic [crlf_pkg::CHUNK-1:0][7:0] chunk_ff;
   logic [1:0] status_ff;
   logic rsp_valid_ff;
   crlf_pkg::rsp_type rsp_ff;

   logic [crlf_pkg::MAXLEN_W-1:0] eff_max;
   logic [crlf_pkg::FILL_W-1:0]   limit;
   logic [crlf_pkg::FILL_W-1:0]   q_fill;
   logic [crlf_pkg::POS_W-1:0]    q_rp;
   logic                          mem_we;
   logic [AW-1:0]                 waddr;
   logic [AW-1:0]                 raddr;
   logic [crlf_pkg::POS_W-1:0]    rpos;
   logic                          out_free;
   logic [crlf_pkg::FILL_W-1:0]   dterm;

   always_comb begin
      if (max_len == '0) eff_max = 9'd1;
      else if (max_len > crlf_pkg::FRAME_CAP) eff_max = crlf_pkg::FRAME_CAP;
      else eff_max = max_len;
   end
   assign limit = {eff_max, 1'b0};

   assign q_pop   = (state_ff == S_IDLE) && q_valid;
   assign q_fill  = fill_ff[q_item.link];
   assign q_rp    = rp_ff[q_item.link];
   assign mem_we  = q_pop && (q_item.action == crlf_pkg::ACT_PUSH) &&
                    (q_fill + 10'd1 <= limit);
   assign waddr   = {q_item.link, q_rp + q_fill[crlf_pkg::POS_W-1:0]};
   assign rpos    = rp_ff[link_ff] + off_ff[crlf_pkg::POS_W-1:0];
   assign raddr   = {link_ff, rpos};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign dterm   = cr_found_ff ? term_ff : lf_pos_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= q_item.in_byte;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < crlf_pkg::LINKS; i++) begin
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  link_ff     <= q_item.link;
                  cur_fill_ff <= q_fill;
                  off_ff      <= '0;
                  cr_found_ff <= 1'b0;
                  lf_found_ff <= 1'b0;
                  if (q_item.action == crlf_pkg::ACT_PUSH) begin
                     if (q_fill + 10'd1 > limit) begin
                        fill_ff[q_item.link] <= '0;
                        rp_ff[q_item.link]   <= '0;
                     end else begin
                        fill_ff[q_item.link] <= q_fill + 10'd1;
                     end
                  end else if (q_fill == '0) begin
                     status_ff <= crlf_pkg::ST_EMPTY;
                     state_ff  <= S_SIMPLE_OUT;
                  end else begin
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               // A CR anywhere wins over an earlier LF, so the scan only stops early on CR.
               if (rdata_ff == crlf_pkg::CHAR_CR) begin
                  cr_found_ff <= 1'b1;
                  term_ff     <= off_ff;
                  state_ff    <= S_DECIDE;
               end else begin
                  if (rdata_ff == crlf_pkg::CHAR_LF && !lf_found_ff) begin
                     lf_found_ff <= 1'b1;
                     lf_pos_ff   <= off_ff;
                  end
                  if (off_ff + 10'd1 == cur_fill_ff) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     off_ff   <= off_ff + 10'd1;
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_DECIDE: begin
               if (!cr_found_ff && !lf_found_ff) begin
                  status_ff <= crlf_pkg::ST_NO_TERM;
                  state_ff  <= S_SIMPLE_OUT;
               end else if (dterm == '0 || dterm > {1'b0, eff_max}) begin
                  rp_ff[link_ff]   <= rp_ff[link_ff] + 9'd1;
                  fill_ff[link_ff] <= cur_fill_ff - 10'd1;
                  status_ff <= crlf_pkg::ST_DROP;
                  state_ff  <= S_SIMPLE_OUT;
               end else begin
                  len_ff   <= dterm;
                  off_ff   <= '0;
                  k_ff     <= '0;
                  chunk_ff <= '0;
                  state_ff <= S_EMIT_RD;
               end
            end
            S_EMIT_RD: state_ff <= S_EMIT_CAP;
            S_EMIT_CAP: begin
               chunk_ff[k_ff[2:0]] <= rdata_ff;
               k_ff   <= k_ff + 4'd1;
               off_ff <= off_ff + 10'd1;
               if (k_ff == 4'd7 || off_ff + 10'd1 == len_ff) state_ff <= S_EMIT_OUT;
               else state_ff <= S_EMIT_RD;
            end
            S_EMIT_OUT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.out_link    <= link_ff;
                  rsp_ff.status      <= crlf_pkg::ST_FRAME;
                  rsp_ff.bytes       <= chunk_ff;
                  rsp_ff.byte_count  <= k_ff;
                  rsp_ff.last        <= (off_ff == len_ff);
                  chunk_ff <= '0;
                  k_ff     <= '0;
                  if (off_ff != len_ff) begin
                     state_ff <= S_EMIT_RD;
                  end else if (cr_found_ff && cur_fill_ff > len_ff + 10'd1) begin
                     off_ff   <= len_ff + 10'd1;
                     state_ff <= S_TAIL_RD;
                  end else begin
                     rp_ff[link_ff]   <= rp_ff[link_ff] + len_ff[crlf_pkg::POS_W-1:0] + 9'd1;
                     fill_ff[link_ff] <= cur_fill_ff - len_ff - 10'd1;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_TAIL_RD: state_ff <= S_TAIL_CHK;
            S_TAIL_CHK: begin
               // An LF right after a CR terminator is swallowed with it.
               if (rdata_ff == crlf_pkg::CHAR_LF) begin
                  rp_ff[link_ff]   <= rp_ff[link_ff] + len_ff[crlf_pkg::POS_W-1:0] + 9'd2;
                  fill_ff[link_ff] <= cur_fill_ff - len_ff - 10'd2;
               end else begin
                  rp_ff[link_ff]   <= rp_ff[link_ff] + len_ff[crlf_pkg::POS_W-1:0] + 9'd1;
                  fill_ff[link_ff] <= cur_fill_ff - len_ff - 10'd1;
               end
               state_ff <= S_IDLE;
            end
            S_SIMPLE_OUT: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.out_link   <= link_ff;
                  rsp_ff.status     <= status_ff;
                  rsp_ff.bytes      <= '0;
                  rsp_ff.byte_count <= '0;
                  rsp_ff.last       <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* hdl/cr_lf_line_frame_assembler.sv */
// Line frame assembler for four serial links.
// The request channel (req_valid, req_stall) carries one word per item: a push
// appends req_in_byte to the buffer of link req_link (a full buffer is emptied
// instead), a poll asks that link for a frame ending in CR or LF. A push
// produces no response; a poll produces one response word, or for good frames
// one word per chunk of up to eight bytes, with rsp_last set on the final one.
// A push leaves the engine idle, so pushes can follow one per cycle while no
// poll is in progress. A poll scans the link buffer byte by byte, a read state
// and then a check state per byte, through the single read port of the byte
// memory, and reads the frame bytes again to fill each chunk.
// Requests queue in a two-entry buffer ahead of the engine, so req_stall rises
// only when that buffer is full. Responses sit in an output register that
// holds a valid response while rsp_stall is high; the next one then waits.
// Synchronous reset empties every link and sets the maximum frame length to
// 256. csr_wr_en writes it from csr_wr_data; write it only while idle.
module cr_lf_line_frame_assembler (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [1:0] req_link,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_link,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_byte_0,
   output logic [7:0] rsp_out_byte_1,
   output logic [7:0] rsp_out_byte_2,
   output logic [7:0] rsp_out_byte_3,
   output logic [7:0] rsp_out_byte_4,
   output logic [7:0] rsp_out_byte_5,
   output logic [7:0] rsp_out_byte_6,
   output logic [7:0] rsp_out_byte_7,
   output logic [3:0] rsp_byte_count,
   output logic       rsp_last
);

   logic [8:0]         max_len_ff;
   crlf_pkg::item_type req_item;
   crlf_pkg::item_type q_item;
   logic               q_valid;
   logic               q_pop;
   crlf_pkg::rsp_type  rsp;

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= crlf_pkg::FRAME_CAP;
      else if (csr_wr_en) max_len_ff <= csr_wr_data;
   end

   assign req_item.action  = req_action;
   assign req_item.link    = req_link;
   assign req_item.in_byte = req_in_byte;

   crlf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   crlf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .max_len   (max_len_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_out_link   = rsp.out_link;
   assign rsp_status     = rsp.status;
   assign rsp_out_byte_0 = rsp.bytes[0];
   assign rsp_out_byte_1 = rsp.bytes[1];
   assign rsp_out_byte_2 = rsp.bytes[2];
   assign rsp_out_byte_3 = rsp.bytes[3];
   assign rsp_out_byte_4 = rsp.bytes[4];
   assign rsp_out_byte_5 = rsp.bytes[5];
   assign rsp_out_byte_6 = rsp.bytes[6];
   assign rsp_out_byte_7 = rsp.bytes[7];
   assign rsp_byte_count = rsp.byte_count;
   assign rsp_last       = rsp.last;

endmodule
